### hdl/assert_macros.svh
// assertion macros shared by the ssd frame match modules
// expects signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, off while reset is high
`define SBFM_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("sbfm assertion failed");

// consequent checked in the cycle after the antecedent
`define SBFM_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbfm assertion failed");

`endif

### hdl/sbfm_pkg.sv
// shared types and constants of the ssd best frame match core
// no dependencies
package sbfm_pkg;

   localparam int PIXEL_W    = 8;
   localparam int SQ_W       = 2 * PIXEL_W;
   localparam int ID_W       = 16;
   localparam int SUM_W      = 38;
   localparam int CFG_W      = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

   // one squared pixel difference on its way to the accumulator
   typedef struct packed {
      logic [SQ_W-1:0] sq_diff;
      logic [ID_W-1:0] cand_id;
      logic            frame_end;
   } entry_type;

endpackage

### hdl/sbfm_front.sv
// front stage: takes pixel pairs, squares their difference, feeds the queue
// depends on sbfm_pkg
module sbfm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sbfm_pkg::PIXEL_W-1:0]  req_ref_pixel,
   input  logic [sbfm_pkg::PIXEL_W-1:0]  req_cand_pixel,
   input  logic [sbfm_pkg::ID_W-1:0]     req_cand_id,
   input  logic                          req_frame_end,
   output logic                          push_valid,
   input  logic                          push_ready,
   output sbfm_pkg::entry_type           push_entry
);
   import sbfm_pkg::*;

   logic                valid_ff, valid_in;
   entry_type           entry_ff, entry_in;
   logic [PIXEL_W-1:0]  abs_diff;

   assign req_ready = !valid_ff || push_ready;

   always_comb begin
      if (req_ref_pixel >= req_cand_pixel) begin
         abs_diff = req_ref_pixel - req_cand_pixel;
      end else begin
         abs_diff = req_cand_pixel - req_ref_pixel;
      end
      entry_in.sq_diff   = SQ_W'(abs_diff) * SQ_W'(abs_diff);
      entry_in.cand_id   = req_cand_id;
      entry_in.frame_end = req_frame_end;
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         entry_ff <= entry_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

endmodule

### hdl/sbfm_queue.sv
// short queue between the front stage and the accumulator
// depends on sbfm_pkg and assert_macros.svh
`include "assert_macros.svh"

module sbfm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  sbfm_pkg::entry_type  push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output sbfm_pkg::entry_type  pop_entry
);
   import sbfm_pkg::*;

   entry_type               mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push, do_pop;

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   `SBFM_ASSERT(a_count_bound, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
   `SBFM_ASSERT_NEXT(a_count_track, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1)

endmodule

### hdl/sbfm_back.sv
// back stage: saturating accumulate, best frame compare, result register
// depends on sbfm_pkg and assert_macros.svh
`include "assert_macros.svh"

module sbfm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   input  logic [sbfm_pkg::CFG_W-1:0]  csr_candidates_per_search,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  sbfm_pkg::entry_type         pop_entry,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sbfm_pkg::SUM_W-1:0]  rsp_frame_ssd,
   output logic [sbfm_pkg::ID_W-1:0]   rsp_best_id,
   output logic [sbfm_pkg::SUM_W-1:0]  rsp_best_ssd,
   output logic                        rsp_search_done
);
   import sbfm_pkg::*;

   logic [CFG_W-1:0]  cfg_ff, cfg_in;
   logic [SUM_W-1:0]  run_ff, run_in;
   logic [SUM_W-1:0]  best_ff, best_in;
   logic [ID_W-1:0]   best_id_ff, best_id_in;
   logic [CFG_W-1:0]  seen_ff, seen_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_frame_ff, rsp_best_ssd_ff;
   logic [ID_W-1:0]   rsp_best_id_ff;
   logic              rsp_done_ff;

   logic              do_pop, pop_last;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  frame_sum, new_best;
   logic [ID_W-1:0]   new_best_id;
   logic [CFG_W:0]    seen_next;
   logic              better, done;

   // a frame end needs the result register free, plain bytes never wait
   assign pop_ready = !pop_entry.frame_end || !rsp_valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;
   assign pop_last  = do_pop && pop_entry.frame_end;

   always_comb begin
      sum_wide    = {1'b0, run_ff} + (SUM_W + 1)'(pop_entry.sq_diff);
      frame_sum   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      better      = frame_sum < best_ff;
      new_best    = better ? frame_sum : best_ff;
      new_best_id = better ? pop_entry.cand_id : best_id_ff;
      seen_next   = {1'b0, seen_ff} + 1'b1;
      done        = seen_next >= {1'b0, cfg_ff};

      cfg_in     = csr_valid ? csr_candidates_per_search : cfg_ff;
      run_in     = run_ff;
      best_in    = best_ff;
      best_id_in = best_id_ff;
      seen_in    = seen_ff;
      if (do_pop) begin
         run_in = pop_entry.frame_end ? '0 : frame_sum;
      end
      if (pop_last) begin
         if (done) begin
            best_in    = SUM_MAX;
            best_id_in = '0;
            seen_in    = '0;
         end else begin
            best_in    = new_best;
            best_id_in = new_best_id;
            seen_in    = seen_next[CFG_W-1:0];
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop_last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         run_ff       <= '0;
         best_ff      <= SUM_MAX;
         best_id_ff   <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         run_ff       <= run_in;
         best_ff      <= best_in;
         best_id_ff   <= best_id_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_last) begin
         rsp_frame_ff    <= frame_sum;
         rsp_best_ssd_ff <= new_best;
         rsp_best_id_ff  <= new_best_id;
         rsp_done_ff     <= done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_ssd   = rsp_frame_ff;
   assign rsp_best_ssd    = rsp_best_ssd_ff;
   assign rsp_best_id     = rsp_best_id_ff;
   assign rsp_search_done = rsp_done_ff;

   `SBFM_ASSERT(a_best_le_frame, !rsp_valid_ff || (rsp_best_ssd_ff <= rsp_frame_ff))
   `SBFM_ASSERT_NEXT(a_search_clear, pop_last && done, (seen_ff == '0) && (best_ff == SUM_MAX))

endmodule

### hdl/ssd_best_frame_match_core.sv
// ssd best frame match core: front stage, queue and accumulate stage
// depends on sbfm_pkg, sbfm_front, sbfm_queue and sbfm_back
// path: a frame-end request passes the front register, the queue and the result register to rsp_valid
// throughput: one request per cycle unless a held result stalls a frame end, set by the single square-accumulate unit
// a result held by rsp_ready stalls the next frame end; four later requests fit in behind it
// reset: synchronous; clears the search, sets candidates_per_search to 1
module ssd_best_frame_match_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sbfm_pkg::CFG_W-1:0]  csr_candidates_per_search,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [sbfm_pkg::PIXEL_W-1:0] req_ref_pixel,
   input  logic [sbfm_pkg::PIXEL_W-1:0] req_cand_pixel,
   input  logic [sbfm_pkg::ID_W-1:0]   req_cand_id,
   input  logic                        req_frame_end,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sbfm_pkg::SUM_W-1:0]  rsp_frame_ssd,
   output logic [sbfm_pkg::ID_W-1:0]   rsp_best_id,
   output logic [sbfm_pkg::SUM_W-1:0]  rsp_best_ssd,
   output logic                        rsp_search_done
);
   import sbfm_pkg::*;

   logic       push_valid, push_ready;
   entry_type  push_entry;
   logic       pop_valid, pop_ready;
   entry_type  pop_entry;

   assign csr_ready = 1'b1;

   sbfm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ref_pixel  (req_ref_pixel),
      .req_cand_pixel (req_cand_pixel),
      .req_cand_id    (req_cand_id),
      .req_frame_end  (req_frame_end),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   sbfm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   sbfm_back u_back (
      .clock                     (clock),
      .reset                     (reset),
      .csr_valid                 (csr_valid),
      .csr_candidates_per_search (csr_candidates_per_search),
      .pop_valid                 (pop_valid),
      .pop_ready                 (pop_ready),
      .pop_entry                 (pop_entry),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_frame_ssd             (rsp_frame_ssd),
      .rsp_best_id               (rsp_best_id),
      .rsp_best_ssd              (rsp_best_ssd),
      .rsp_search_done           (rsp_search_done)
   );

endmodule

### dv/ssd_best_frame_match_checker.sv
// result checker for the ssd best frame match core: tracks the search and compares results
// depends on sbfm_pkg; instantiated by the testbench top beside the core
module ssd_best_frame_match_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [sbfm_pkg::CFG_W-1:0]    csr_candidates_per_search,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [sbfm_pkg::PIXEL_W-1:0]  req_ref_pixel,
   input  logic [sbfm_pkg::PIXEL_W-1:0]  req_cand_pixel,
   input  logic [sbfm_pkg::ID_W-1:0]     req_cand_id,
   input  logic                          req_frame_end,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [sbfm_pkg::SUM_W-1:0]    rsp_frame_ssd,
   input  logic [sbfm_pkg::ID_W-1:0]     rsp_best_id,
   input  logic [sbfm_pkg::SUM_W-1:0]    rsp_best_ssd,
   input  logic                          rsp_search_done,
   output int unsigned                   mismatch_count,
   output int unsigned                   results_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import sbfm_pkg::*;

   typedef struct packed {
      logic [SUM_W-1:0] frame_ssd;
      logic [ID_W-1:0]  best_id;
      logic [SUM_W-1:0] best_ssd;
      logic             search_done;
   } frame_match_type;

   frame_match_type  pending_matches[$];
   logic [CFG_W-1:0] search_length;
   logic [SUM_W-1:0] frame_sum;
   logic [SUM_W-1:0] best_sum;
   logic [ID_W-1:0]  best_frame;
   logic [CFG_W-1:0] frames_closed;

   task automatic accumulate_pixel(input logic [PIXEL_W-1:0] ref_pix,
                                   input logic [PIXEL_W-1:0] cand_pix,
                                   input logic [ID_W-1:0] id,
                                   input logic last);
      logic [PIXEL_W-1:0] diff;
      logic [SQ_W-1:0]    square;
      logic [SUM_W:0]     total;
      logic [CFG_W:0]     closed;
      frame_match_type    match;
      diff = (ref_pix >= cand_pix) ? ref_pix - cand_pix : cand_pix - ref_pix;
      square = diff * diff;
      total = {1'b0, frame_sum} + square;
      // the sum sticks at all ones once it overflows
      frame_sum = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
      if (last) begin
         // strictly smaller only, so the earliest of equal frames stays best
         if (frame_sum < best_sum) begin
            best_sum = frame_sum;
            best_frame = id;
         end
         closed = {1'b0, frames_closed} + 1'b1;
         match.frame_ssd = frame_sum;
         match.best_id = best_frame;
         match.best_ssd = best_sum;
         match.search_done = (closed >= {1'b0, search_length});
         pending_matches.push_back(match);
         frame_sum = '0;
         if (match.search_done) begin
            best_sum = SUM_MAX;
            best_frame = '0;
            frames_closed = '0;
         end else begin
            frames_closed = closed[CFG_W-1:0];
         end
      end
   endtask

   task automatic compare_field(input string field, input logic [SUM_W-1:0] want,
                                input logic [SUM_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      frame_match_type want;
      if (reset) begin
         search_length = CFG_RESET;
         frame_sum = '0;
         best_sum = SUM_MAX;
         best_frame = '0;
         frames_closed = '0;
         mismatch_count = 0;
         pending_matches.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            search_length = csr_candidates_per_search;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_matches.size() == 0) begin
               $error("unexpected result: frame_ssd %0d best_id %0d", rsp_frame_ssd,
                      rsp_best_id);
               mismatch_count++;
            end else begin
               want = pending_matches.pop_front();
               compare_field("frame_ssd", want.frame_ssd, rsp_frame_ssd);
               compare_field("best_id", want.best_id, rsp_best_id);
               compare_field("best_ssd", want.best_ssd, rsp_best_ssd);
               compare_field("search_done", want.search_done, rsp_search_done);
            end
         end
         // results leave only after passing the front register, the queue and the result register, so compare first
         if (req_valid && req_ready) begin
            accumulate_pixel(req_ref_pixel, req_cand_pixel, req_cand_id, req_frame_end);
         end
      end
      results_pending = pending_matches.size();
   end

endmodule

### dv/testbench.sv
// testbench top for the ssd best frame match core: request, csr and stall stimulus
// depends on sbfm_pkg, ssd_best_frame_match_core and ssd_best_frame_match_checker
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sbfm_pkg::*;

   localparam int unsigned RANDOM_REQUESTS = 1100;
   localparam int unsigned IDLE_LIMIT      = 1000;
   localparam int unsigned SETTLE_CYCLES   = 10;

   typedef enum {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE} ready_mode_type;
   typedef enum {PIX_RANDOM, PIX_EQUAL, PIX_EXTREME, PIX_NEAR} pixel_style_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CFG_W-1:0]   csr_count = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [PIXEL_W-1:0] req_ref_pixel = '0;
   logic [PIXEL_W-1:0] req_cand_pixel = '0;
   logic [ID_W-1:0]    req_cand_id = '0;
   logic               req_frame_end = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [SUM_W-1:0]   rsp_frame_ssd;
   logic [ID_W-1:0]    rsp_best_id;
   logic [SUM_W-1:0]   rsp_best_ssd;
   logic               rsp_search_done;

   int unsigned        mismatch_count;
   int unsigned        results_pending;
   int unsigned        requests_sent = 0;
   int unsigned        frames_sent = 0;
   int unsigned        count_writes = 0;
   int unsigned        burst_left = 0;
   int unsigned        idle_cycles = 0;
   ready_mode_type     ready_mode = READY_ALWAYS;
   int unsigned        mode_left = 0;
   int unsigned        ready_phase = 0;
   logic [PIXEL_W-1:0] last_ref[$];
   logic [PIXEL_W-1:0] last_cand[$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   ssd_best_frame_match_core dut (
      .clock                     (clock),
      .reset                     (reset),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_candidates_per_search (csr_count),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_ref_pixel             (req_ref_pixel),
      .req_cand_pixel            (req_cand_pixel),
      .req_cand_id               (req_cand_id),
      .req_frame_end             (req_frame_end),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_frame_ssd             (rsp_frame_ssd),
      .rsp_best_id               (rsp_best_id),
      .rsp_best_ssd              (rsp_best_ssd),
      .rsp_search_done           (rsp_search_done)
   );

   ssd_best_frame_match_checker checker_inst (
      .clock                     (clock),
      .reset                     (reset),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_candidates_per_search (csr_count),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_ref_pixel             (req_ref_pixel),
      .req_cand_pixel            (req_cand_pixel),
      .req_cand_id               (req_cand_id),
      .req_frame_end             (req_frame_end),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_frame_ssd             (rsp_frame_ssd),
      .rsp_best_id               (rsp_best_id),
      .rsp_best_ssd              (rsp_best_ssd),
      .rsp_search_done           (rsp_search_done),
      .mismatch_count            (mismatch_count),
      .results_pending           (results_pending)
   );

   // result back-pressure, switching at random between four stall modes
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      ready_phase++;
      case (ready_mode)
         READY_ALWAYS:  rsp_ready <= 1'b1;
         READY_COIN:    rsp_ready <= ($urandom_range(0, 1) == 1);
         READY_PATTERN: rsp_ready <= ((ready_phase % 7) >= 3);
         default:       rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   // ready is sampled at the falling edge, where it already holds its value for the next rise
   task automatic write_candidate_count(input logic [CFG_W-1:0] count);
      logic taken;
      csr_valid <= 1'b1;
      csr_count <= count;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (taken !== 1'b1);
      csr_valid <= 1'b0;
      count_writes++;
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] ref_pix,
                             input logic [PIXEL_W-1:0] cand_pix,
                             input logic [ID_W-1:0] id, input logic last);
      logic taken;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_ref_pixel <= ref_pix;
      req_cand_pixel <= cand_pix;
      req_cand_id <= id;
      req_frame_end <= last;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (taken !== 1'b1);
      requests_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // a replayed frame repeats the previous bytes under a new id, forcing a tie
   task automatic send_frame(input logic [ID_W-1:0] id, input int unsigned len);
      pixel_style_type    style;
      logic [PIXEL_W-1:0] r;
      logic [PIXEL_W-1:0] c;
      logic [ID_W-1:0]    byte_id;
      bit                 replay;
      bit                 stray_ids;
      replay = (last_ref.size() != 0) && ($urandom_range(0, 3) == 0);
      style = pixel_style_type'($urandom_range(0, 3));
      stray_ids = ($urandom_range(0, 4) == 0);
      if (replay) begin
         len = last_ref.size();
      end else begin
         last_ref.delete();
         last_cand.delete();
      end
      for (int unsigned i = 0; i < len; i++) begin
         if (replay) begin
            r = last_ref[i];
            c = last_cand[i];
         end else begin
            r = PIXEL_W'($urandom_range(0, 255));
            case (style)
               PIX_EQUAL: c = r;
               PIX_EXTREME: begin
                  r = ($urandom_range(0, 1) == 1) ? '1 : '0;
                  c = ($urandom_range(0, 1) == 1) ? '1 : '0;
               end
               PIX_NEAR: c = r + PIXEL_W'($urandom_range(0, 6)) - PIXEL_W'(3);
               default:  c = PIXEL_W'($urandom_range(0, 255));
            endcase
            last_ref.push_back(r);
            last_cand.push_back(c);
         end
         // only the id on the closing byte counts
         byte_id = (stray_ids && i + 1 < len) ? ID_W'($urandom()) : id;
         send_pixel(r, c, byte_id, i + 1 == len);
      end
      frames_sent++;
   endtask

   initial begin
      logic [CFG_W-1:0] count;
      int unsigned      frames;
      int unsigned      len;
      int unsigned      random_start;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // equal sums keep the earlier id, a zero sum then wins and ends the search
      write_candidate_count(8'd3);
      send_pixel(8'd0, 8'd255, 16'hFFFF, 1'b1);
      send_pixel(8'd255, 8'd0, 16'h0000, 1'b1);
      send_pixel(8'd255, 8'd255, 16'h1234, 1'b0);
      send_pixel(8'd0, 8'd0, 16'h1234, 1'b1);
      wait_for_results();

      // a count of zero ends the search at every frame
      write_candidate_count(8'd0);
      send_pixel(8'h80, 8'h7F, 16'hAAAA, 1'b1);
      send_pixel(8'h55, 8'h55, 16'h5555, 1'b0);
      send_pixel(8'hAA, 8'h55, 16'h5555, 1'b1);
      wait_for_results();

      // count lowered below the frames already closed
      write_candidate_count(8'd4);
      send_pixel(8'h0F, 8'hF0, 16'h00FF, 1'b1);
      send_pixel(8'hF0, 8'h0F, 16'hFF00, 1'b1);
      wait_for_results();
      write_candidate_count(8'd1);
      send_pixel(8'd255, 8'd0, 16'hFFFF, 1'b0);
      send_pixel(8'd0, 8'd255, 16'h0000, 1'b1);
      wait_for_results();

      random_start = requests_sent;
      count = 8'd255;
      frames = 256;
      while (requests_sent - random_start < RANDOM_REQUESTS) begin
         write_candidate_count(count);
         for (int unsigned f = 0; f < frames; f++) begin
            if (count == 8'd255) begin
               len = $urandom_range(1, 2);
            end else begin
               len = ($urandom_range(0, 59) == 0) ? $urandom_range(200, 400)
                                                   : $urandom_range(1, 6);
            end
            send_frame(ID_W'($urandom_range(0, 65535)), len);
         end
         wait_for_results();
         case ($urandom_range(0, 5))
            0:       count = 8'd1;
            1:       count = 8'd0;
            2, 3:    count = CFG_W'($urandom_range(2, 8));
            4:       count = CFG_W'($urandom_range(9, 40));
            default: count = CFG_W'($urandom_range(1, 4));
         endcase
         frames = $urandom_range(1, 16);
      end

      wait_for_results();
      $display("covered %0d requests in %0d frames under %0d candidate count writes",
               requests_sent, frames_sent, count_writes);
      $display("including ties, zero and full counts, extreme pixels and a count lowered mid-search");
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
